// ----- design/alpf_pkg.sv -----
// Shared types, constants and microcode program of the acceleration-limited position follower.
`timescale 1ns / 1ps

package alpf_pkg;

  localparam int PC_W = 5;
  localparam int TIME_FRAC = 16;

  // Request kinds on the input tuser field
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_JUMP = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_POS_MIN  = 3'd0;
  localparam logic [2:0] REG_POS_MAX  = 3'd1;
  localparam logic [2:0] REG_SPEED    = 3'd2;
  localparam logic [2:0] REG_SLOWDOWN = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;
  localparam logic [2:0] REG_ACCEL    = 3'd5;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_DIST     = 4'd2,
    OP_ABS      = 4'd3,
    OP_MUL      = 4'd4,
    OP_DIV_INIT = 4'd5,
    OP_DIV_STEP = 4'd6,
    OP_QUOT     = 4'd7,
    OP_ZERO     = 4'd8,
    OP_CLAMP    = 4'd9,
    OP_DV       = 4'd10,
    OP_RAMP     = 4'd11,
    OP_PMUL     = 4'd12,
    OP_POS      = 4'd13,
    OP_SET      = 4'd14,
    OP_JUMP     = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT     = 4'd0,
    C_GOTO     = 4'd1,
    C_WAIT_IN  = 4'd2,
    C_IF_SET   = 4'd3,
    C_IF_JUMP  = 4'd4,
    C_IF_IDLE  = 4'd5,
    C_IF_NEAR  = 4'd6,
    C_IF_FAR   = 4'd7,
    C_LOOP     = 4'd8,
    C_WAIT_OUT = 4'd9
  } cond_t;

  typedef struct packed {
    logic  out_step;
    op_t   op;
    cond_t cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_ZERO  = 5'd10;
  localparam logic [PC_W-1:0] PC_CLAMP = 5'd11;
  localparam logic [PC_W-1:0] PC_DV    = 5'd12;
  localparam logic [PC_W-1:0] PC_SET   = 5'd16;
  localparam logic [PC_W-1:0] PC_JUMP  = 5'd17;
  localparam logic [PC_W-1:0] PC_ODIST = 5'd18;
  localparam logic [PC_W-1:0] PC_DIV   = 5'd8;
  localparam logic [PC_W-1:0] PC_START = 5'd0;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{out_step: 1'b0, op: OP_NOP, cond: C_GOTO, target: PC_START};
    case (addr)
      5'd0:  w = '{1'b0, OP_ACCEPT,   C_WAIT_IN,  PC_START};
      5'd1:  w = '{1'b0, OP_NOP,      C_IF_SET,   PC_SET};
      5'd2:  w = '{1'b0, OP_NOP,      C_IF_JUMP,  PC_JUMP};
      5'd3:  w = '{1'b0, OP_NOP,      C_IF_IDLE,  PC_ODIST};
      5'd4:  w = '{1'b0, OP_DIST,     C_NEXT,     PC_START};
      5'd5:  w = '{1'b0, OP_ABS,      C_NEXT,     PC_START};
      5'd6:  w = '{1'b0, OP_MUL,      C_IF_NEAR,  PC_ZERO};
      5'd7:  w = '{1'b0, OP_DIV_INIT, C_IF_FAR,   PC_CLAMP};
      5'd8:  w = '{1'b0, OP_DIV_STEP, C_LOOP,     PC_DIV};
      5'd9:  w = '{1'b0, OP_QUOT,     C_GOTO,     PC_DV};
      5'd10: w = '{1'b0, OP_ZERO,     C_GOTO,     PC_DV};
      5'd11: w = '{1'b0, OP_CLAMP,    C_NEXT,     PC_START};
      5'd12: w = '{1'b0, OP_DV,       C_NEXT,     PC_START};
      5'd13: w = '{1'b0, OP_RAMP,     C_NEXT,     PC_START};
      5'd14: w = '{1'b0, OP_PMUL,     C_NEXT,     PC_START};
      5'd15: w = '{1'b0, OP_POS,      C_GOTO,     PC_ODIST};
      5'd16: w = '{1'b0, OP_SET,      C_GOTO,     PC_ODIST};
      5'd17: w = '{1'b0, OP_JUMP,     C_NEXT,     PC_START};
      5'd18: w = '{1'b0, OP_DIST,     C_NEXT,     PC_START};
      5'd19: w = '{1'b0, OP_ABS,      C_NEXT,     PC_START};
      5'd20: w = '{1'b1, OP_NOP,      C_WAIT_OUT, PC_START};
      default: w = '{1'b0, OP_NOP,    C_GOTO,     PC_START};
    endcase
    return w;
  endfunction

endpackage

// ----- design/accel_limited_position_follower.sv -----
// Top level: microcoded acceleration-limited position follower with APB registers.
`timescale 1ns / 1ps

// Acceleration-limited position follower.
// Requests come in on the s_ stream: s_tuser is the request kind (tick, set target,
// jump), s_tdata carries the value and the tick duration. Every request gives one
// result on the m_ stream: position, velocity, distance to target and reached flag.
// Limits, tolerance and acceleration sit in six APB registers at byte addresses 0..20.
// A sequencer steps through a small microcode ROM; one control word per cycle.
// A tick inside the tolerance commands zero speed, one beyond the slowdown distance the
// speed limit; in the slowdown zone a 31-step restoring divider forms the commanded
// speed one quotient bit a cycle. One request is in flight at a time, so no new
// request is taken before the last one is worked out.
// Reset clears position, velocity and target and loads the default registers.
// The result sits in an output register; while the receiver stalls, one more request
// is taken and worked out, then the sequencer waits in its output step and no new
// request is taken until the held result leaves.
module accel_limited_position_follower #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [31:0] new_value, [47:32] elapsed_time
  input  logic [1:0]   s_tuser,   // [1:0] req_type
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // [31:0] position, [63:32] speed,
                                  // [95:64] distance_left, [96] reached, rest zero
);

  localparam logic [30:0] SPEED_RST = 31'(64'd10 << FRAC_BITS);
  localparam logic [30:0] SLOW_RST  = 31'(64'd2 << FRAC_BITS);
  localparam logic [30:0] TOL_RST   = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] ACCEL_RST = 31'(64'd1 << FRAC_BITS);

  // configuration registers
  logic signed [31:0] pos_min, pos_max;
  logic [30:0] speed_limit, slowdown, tol, accel;

  logic cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_min     <= 32'sh8000_0000;
      pos_max     <= 32'sh7fff_ffff;
      speed_limit <= SPEED_RST;
      slowdown    <= SLOW_RST;
      tol         <= TOL_RST;
      accel       <= ACCEL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        alpf_pkg::REG_POS_MIN:  pos_min     <= pwdata;
        alpf_pkg::REG_POS_MAX:  pos_max     <= pwdata;
        alpf_pkg::REG_SPEED:    speed_limit <= pwdata[30:0];
        alpf_pkg::REG_SLOWDOWN: slowdown    <= pwdata[30:0];
        alpf_pkg::REG_TOL:      tol         <= pwdata[30:0];
        alpf_pkg::REG_ACCEL:    accel       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      alpf_pkg::REG_POS_MIN:  prdata = pos_min;
      alpf_pkg::REG_POS_MAX:  prdata = pos_max;
      alpf_pkg::REG_SPEED:    prdata = {1'b0, speed_limit};
      alpf_pkg::REG_SLOWDOWN: prdata = {1'b0, slowdown};
      alpf_pkg::REG_TOL:      prdata = {1'b0, tol};
      alpf_pkg::REG_ACCEL:    prdata = {1'b0, accel};
      default:                prdata = 32'd0;
    endcase
  end

  // sequencer
  logic [alpf_pkg::PC_W-1:0] pc, pc_next;
  alpf_pkg::ucode_t uc;
  logic out_busy;

  assign uc       = alpf_pkg::ucode_rom(pc);
  assign out_busy = m_tvalid & ~m_tready;
  assign s_tready = (uc.op == alpf_pkg::OP_ACCEPT);

  // datapath registers
  logic [1:0]         req_kind;
  logic signed [31:0] in_value;
  logic [15:0]        in_time;
  logic signed [32:0] diff;
  logic [31:0]        adist;
  logic [61:0]        prod;
  logic [30:0]        rem, dvd, quo;
  logic [4:0]         cnt;
  logic signed [31:0] desired;
  logic [30:0]        dv;
  logic [31:0]        pm;
  logic signed [31:0] pos, vel, goal;
  logic [30:0]        thr;

  assign thr = (slowdown == 31'd0) ? 31'd1 : slowdown;

  logic near, far, take;
  assign near = adist <= {1'b0, tol};
  assign far  = adist >= {1'b0, thr};

  always_comb begin
    case (uc.cond)
      alpf_pkg::C_NEXT:     take = 1'b0;
      alpf_pkg::C_GOTO:     take = 1'b1;
      alpf_pkg::C_IF_SET:   take = (req_kind == alpf_pkg::REQ_SET);
      alpf_pkg::C_IF_JUMP:  take = (req_kind == alpf_pkg::REQ_JUMP);
      alpf_pkg::C_IF_IDLE:  take = (req_kind == alpf_pkg::REQ_NONE) || (in_time == 16'd0);
      alpf_pkg::C_IF_NEAR:  take = near;
      alpf_pkg::C_IF_FAR:   take = far;
      alpf_pkg::C_LOOP:     take = (cnt != 5'd0);
      default:              take = 1'b0;
    endcase
    case (uc.cond)
      alpf_pkg::C_WAIT_IN:  pc_next = s_tvalid ? pc + 1'b1 : pc;
      alpf_pkg::C_WAIT_OUT: pc_next = out_busy ? pc : uc.target;
      default:              pc_next = take ? uc.target : pc + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= alpf_pkg::PC_START;
    else     pc <= pc_next;
  end

  // arithmetic for the individual steps
  logic [31:0]        div_trial;
  logic [46:0]        acc_prod;
  logic [31:0]        vel_mag;
  logic [47:0]        pm_prod;
  logic signed [33:0] ramp_sum, pos_sum;
  logic signed [31:0] ramp_res, pos_res, set_res;
  logic [32:0]        diff_mag;

  assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign div_trial = {rem, dvd[30]};
  assign acc_prod  = {16'd0, accel} * {31'd0, in_time};
  assign vel_mag   = vel[31] ? 32'(-vel) : 32'(vel);
  assign pm_prod   = {16'd0, vel_mag} * {32'd0, in_time};

  always_comb begin
    if (vel < desired) begin
      ramp_sum = 34'(vel) + $signed({3'b000, dv});
      ramp_res = (ramp_sum > 34'(desired)) ? desired : 32'(ramp_sum);
    end else begin
      ramp_sum = 34'(vel) - $signed({3'b000, dv});
      ramp_res = (ramp_sum < 34'(desired)) ? desired : 32'(ramp_sum);
    end
  end

  always_comb begin
    if (vel[31]) pos_sum = 34'(pos) - $signed({2'b00, pm});
    else         pos_sum = 34'(pos) + $signed({2'b00, pm});
    if (pos_sum > 34'sh0_7fff_ffff)       pos_res = 32'sh7fff_ffff;
    else if (pos_sum < -34'sh0_8000_0000) pos_res = 32'sh8000_0000;
    else                                  pos_res = 32'(pos_sum);
  end

  always_comb begin
    if (in_value > pos_max)      set_res = pos_max;
    else if (in_value < pos_min) set_res = pos_min;
    else                         set_res = in_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      vel  <= '0;
      goal <= '0;
    end else begin
      case (uc.op)
        alpf_pkg::OP_ACCEPT: begin
          if (s_tvalid) begin
            req_kind <= s_tuser;
            in_value <= s_tdata[31:0];
            in_time  <= s_tdata[47:32];
          end
        end
        alpf_pkg::OP_DIST:     diff <= 33'(goal) - 33'(pos);
        alpf_pkg::OP_ABS:      adist <= diff_mag[31:0];
        alpf_pkg::OP_MUL:      prod <= {31'd0, speed_limit} * {31'd0, adist[30:0]};
        alpf_pkg::OP_DIV_INIT: begin
          rem <= prod[61:31];
          dvd <= prod[30:0];
          cnt <= 5'd30;
        end
        alpf_pkg::OP_DIV_STEP: begin
          // remainder stays below thr, so the trial value fits 32 bits
          if (div_trial >= {1'b0, thr}) begin
            rem <= 31'(div_trial - {1'b0, thr});
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= div_trial[30:0];
            quo <= {quo[29:0], 1'b0};
          end
          dvd <= {dvd[29:0], 1'b0};
          cnt <= cnt - 5'd1;
        end
        alpf_pkg::OP_QUOT:  desired <= diff[32] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        alpf_pkg::OP_ZERO:  desired <= '0;
        alpf_pkg::OP_CLAMP: desired <= diff[32] ? -$signed({1'b0, speed_limit})
                                                : $signed({1'b0, speed_limit});
        alpf_pkg::OP_DV:    dv <= 31'(acc_prod >> alpf_pkg::TIME_FRAC);
        alpf_pkg::OP_RAMP:  vel <= ramp_res;
        alpf_pkg::OP_PMUL:  pm <= 32'(pm_prod >> alpf_pkg::TIME_FRAC);
        alpf_pkg::OP_POS:   pos <= pos_res;
        alpf_pkg::OP_SET:   goal <= set_res;
        alpf_pkg::OP_JUMP: begin
          pos  <= in_value;
          goal <= in_value;
          vel  <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uc.out_step && !out_busy) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, near, adist, vel, pos};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // checks
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> pc == 5'd1)
    else $error("sequencer did not advance after accepting a request");

  a_result_from_out_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(uc.out_step))
    else $error("result raised outside the output step");

  a_out_returns: assert property (@(posedge clk) disable iff (rst)
    uc.out_step && !out_busy |=> pc == alpf_pkg::PC_START)
    else $error("sequencer did not return to accept after output");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    uc.op == alpf_pkg::OP_DIV_STEP && cnt != 5'd0 |=>
      uc.op == alpf_pkg::OP_DIV_STEP && cnt == $past(cnt) - 5'd1)
    else $error("divider loop count broken");

endmodule
